@@ sv/roman_numeral_decoder_unit_defines.svh @@
// assertion macros used by the decoder top level
`ifndef ROMAN_NUMERAL_DECODER_UNIT_DEFINES_SVH
`define ROMAN_NUMERAL_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RND_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RND_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rnd_pkg.sv @@
package rnd_pkg;

  // width of the parenthesis counters
  localparam int PAREN_COUNT_WIDTH = 16;

  // known characters
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_UNKNOWN    = 2'd1,
    STATUS_UNBALANCED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    status_t            status;
  } out_t;

  // decoded character
  typedef struct packed {
    logic [9:0] val;
    logic       known;
    logic       is_open;
    logic       is_close;
  } digit_t;

  function automatic digit_t digit_decode(logic [7:0] ch);
    digit_t d;
    d.val      = 10'd0;
    d.known    = 1'b1;
    d.is_open  = 1'b0;
    d.is_close = 1'b0;
    case (ch)
      CH_M:     d.val = 10'd1000;
      CH_D:     d.val = 10'd500;
      CH_C:     d.val = 10'd100;
      CH_L:     d.val = 10'd50;
      CH_X:     d.val = 10'd10;
      CH_V:     d.val = 10'd5;
      CH_I:     d.val = 10'd1;
      CH_OPEN:  d.is_open = 1'b1;
      CH_CLOSE: d.is_close = 1'b1;
      default:  d.known = 1'b0;
    endcase
    return d;
  endfunction

  // multiply by 1000 as 1024 - 16 - 8, wrapping at 32 bits
  function automatic logic [31:0] times_1000(logic [31:0] t);
    return (t << 10) - (t << 4) - (t << 3);
  endfunction

endpackage

@@ sv/roman_numeral_decoder_unit.sv @@
// channel | direction | payload                      | handshake
// in_     | input     | rnd_pkg::in_t  symbol, last  | in_valid / in_stall
// out_    | output    | rnd_pkg::out_t value, status | out_valid / out_stall
//
// one character per cycle while in_stall is low; a result passes through the input register,
// then one pass of decode, settle, x1000 and final add, into the result register
// synchronous active-low reset clears the accumulator, counters and valid flags
// in_stall rises only when the final character meets a full, stalled result register
`include "roman_numeral_decoder_unit_defines.svh"

module roman_numeral_decoder_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rnd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rnd_pkg::out_t out_data
);

  logic          stage_valid;
  rnd_pkg::in_t  stage_data;
  logic          advance;
  logic          out_free;
  logic          res_valid;
  rnd_pkg::out_t res_data;

  // input register
  rnd_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_data  (stage_data)
  );

  // accumulator and result logic
  rnd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage_valid (stage_valid),
    .stage_data  (stage_data),
    .out_free    (out_free),
    .advance     (advance),
    .res_valid   (res_valid),
    .res_data    (res_data)
  );

  // result register
  rnd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // checks
  `RND_ASSERT_NOW(a_stall_needs_item, in_stall, stage_valid, "stall with empty input register")
  `RND_ASSERT_NEXT(a_last_gives_result, advance && stage_data.last_char, out_valid, "final character produced no result")
  `RND_ASSERT_NOW(a_error_value_zero, out_valid && out_data.status != rnd_pkg::STATUS_OK, out_data.value == 32'sd0, "error result with nonzero value")

endmodule

@@ sv/rnd_in_stage.sv @@
module rnd_in_stage (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  rnd_pkg::in_t in_data,
  input  logic         advance,
  output logic         stage_valid,
  output rnd_pkg::in_t stage_data
);

  logic         stage_valid_r;
  logic         stage_valid_nxt;
  rnd_pkg::in_t stage_data_r;

  // hold while the current transaction cannot move on
  assign in_stall    = stage_valid_r && !advance;
  assign stage_valid = stage_valid_r;
  assign stage_data  = stage_data_r;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (!in_stall) begin
      stage_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_data_r <= in_data;
    end
  end

endmodule

@@ sv/rnd_core.sv @@
module rnd_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          stage_valid,
  input  rnd_pkg::in_t  stage_data,
  input  logic          out_free,
  output logic          advance,
  output logic          res_valid,
  output rnd_pkg::out_t res_data
);

  localparam int CW = rnd_pkg::PAREN_COUNT_WIDTH;

  logic [31:0]   total_r,     total_nxt;
  logic [9:0]    pend_val_r,  pend_val_nxt;
  logic          pend_vld_r,  pend_vld_nxt;
  logic [CW-1:0] open_cnt_r,  open_cnt_nxt;
  logic [CW-1:0] close_cnt_r, close_cnt_nxt;
  logic          bad_r,       bad_nxt;

  rnd_pkg::digit_t dig;
  logic [31:0]     pend_ext;
  logic [31:0]     settled;
  logic [31:0]     scaled;
  logic [31:0]     final_total;
  logic [9:0]      pend_val_a;
  logic            pend_vld_a;
  logic [CW-1:0]   open_cnt_a;
  logic [CW-1:0]   close_cnt_a;
  logic            bad_a;

  // a non-final character never waits on the result side
  assign advance = stage_valid && (!stage_data.last_char || out_free);
  assign dig     = rnd_pkg::digit_decode(stage_data.symbol);
  assign pend_ext = {22'd0, pend_val_r};

  // settle the held digit, then scale on a closing parenthesis
  always_comb begin
    settled = total_r;
    if (dig.known && pend_vld_r) begin
      if (pend_val_r >= dig.val) begin
        settled = total_r + pend_ext;
      end else begin
        settled = total_r - pend_ext;
      end
    end
    scaled = (dig.known && dig.is_close) ? rnd_pkg::times_1000(settled) : settled;
  end

  // held digit, counters and error flag after this character
  always_comb begin
    pend_val_a  = pend_val_r;
    pend_vld_a  = pend_vld_r;
    open_cnt_a  = open_cnt_r;
    close_cnt_a = close_cnt_r;
    bad_a       = bad_r || !dig.known;
    if (dig.known) begin
      if (dig.is_open) begin
        pend_vld_a = 1'b0;
        open_cnt_a = open_cnt_r + 1'b1;
      end else if (dig.is_close) begin
        pend_vld_a  = 1'b0;
        close_cnt_a = close_cnt_r + 1'b1;
      end else begin
        pend_vld_a = 1'b1;
        pend_val_a = dig.val;
      end
    end
    final_total = pend_vld_a ? scaled + {22'd0, pend_val_a} : scaled;
  end

  // next state and result
  always_comb begin
    total_nxt       = total_r;
    pend_val_nxt    = pend_val_r;
    pend_vld_nxt    = pend_vld_r;
    open_cnt_nxt    = open_cnt_r;
    close_cnt_nxt   = close_cnt_r;
    bad_nxt         = bad_r;
    res_valid       = 1'b0;
    res_data.value  = final_total;
    res_data.status = rnd_pkg::STATUS_OK;
    if (bad_a) begin
      res_data.value  = 32'sd0;
      res_data.status = rnd_pkg::STATUS_UNKNOWN;
    end else if (open_cnt_a != close_cnt_a) begin
      res_data.value  = 32'sd0;
      res_data.status = rnd_pkg::STATUS_UNBALANCED;
    end
    if (advance) begin
      if (stage_data.last_char) begin
        res_valid     = 1'b1;
        total_nxt     = 32'd0;
        pend_val_nxt  = 10'd0;
        pend_vld_nxt  = 1'b0;
        open_cnt_nxt  = '0;
        close_cnt_nxt = '0;
        bad_nxt       = 1'b0;
      end else begin
        total_nxt     = scaled;
        pend_val_nxt  = pend_val_a;
        pend_vld_nxt  = pend_vld_a;
        open_cnt_nxt  = open_cnt_a;
        close_cnt_nxt = close_cnt_a;
        bad_nxt       = bad_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= 32'd0;
      pend_val_r  <= 10'd0;
      pend_vld_r  <= 1'b0;
      open_cnt_r  <= '0;
      close_cnt_r <= '0;
      bad_r       <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      pend_val_r  <= pend_val_nxt;
      pend_vld_r  <= pend_vld_nxt;
      open_cnt_r  <= open_cnt_nxt;
      close_cnt_r <= close_cnt_nxt;
      bad_r       <= bad_nxt;
    end
  end

endmodule

@@ sv/rnd_out_stage.sv @@
module rnd_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  rnd_pkg::out_t res_data,
  output logic          out_free,
  output logic          out_valid,
  input  logic          out_stall,
  output rnd_pkg::out_t out_data
);

  logic          out_valid_r;
  logic          out_valid_nxt;
  rnd_pkg::out_t out_data_r;

  // register can take a result when empty or being drained
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_data_r <= res_data;
    end
  end

endmodule

@@ tb/roman_numeral_decoder_unit_tb.sv @@
module roman_numeral_decoder_unit_tb;

  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AFTER  = 40;
  localparam int RANDOM_CHARS = 1650;
  localparam int DRAIN_CYCLES = 20;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  rnd_pkg::in_t   in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  rnd_pkg::out_t  out_data;

  // characters waiting to be sent and decoded numbers waiting to come out
  rnd_pkg::in_t   char_q[$];
  rnd_pkg::out_t  numeral_q[$];
  int    errors = 0;
  int    results_seen = 0;

  // shadow of the decoder state
  logic [31:0]                           acc_total;
  logic [9:0]                            held_digit;
  logic                                  held_valid;
  logic [rnd_pkg::PAREN_COUNT_WIDTH-1:0] opens;
  logic [rnd_pkg::PAREN_COUNT_WIDTH-1:0] closes;
  logic                                  bad_seen;

  roman_numeral_decoder_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic clear_numeral();
    acc_total  = '0;
    held_digit = '0;
    held_valid = 1'b0;
    opens      = '0;
    closes     = '0;
    bad_seen   = 1'b0;
  endtask

  // fold one accepted character into the shadow state, queue a number on the last one
  task automatic decode_char(rnd_pkg::in_t item);
    logic [9:0]    dval;
    logic          known;
    rnd_pkg::out_t res;
    known = 1'b1;
    dval  = 10'd0;
    case (item.symbol)
      rnd_pkg::CH_M:     dval = 10'd1000;
      rnd_pkg::CH_D:     dval = 10'd500;
      rnd_pkg::CH_C:     dval = 10'd100;
      rnd_pkg::CH_L:     dval = 10'd50;
      rnd_pkg::CH_X:     dval = 10'd10;
      rnd_pkg::CH_V:     dval = 10'd5;
      rnd_pkg::CH_I:     dval = 10'd1;
      rnd_pkg::CH_OPEN, rnd_pkg::CH_CLOSE: dval = 10'd0;
      default:  known = 1'b0;
    endcase
    if (!known) begin
      bad_seen = 1'b1;
    end else begin
      // settle the held digit against the new one
      if (held_valid) begin
        if (held_digit >= dval) acc_total = acc_total + {22'd0, held_digit};
        else acc_total = acc_total - {22'd0, held_digit};
        held_valid = 1'b0;
      end
      if (item.symbol == rnd_pkg::CH_OPEN) begin
        opens = opens + 1'b1;
      end else if (item.symbol == rnd_pkg::CH_CLOSE) begin
        acc_total = acc_total * 32'd1000;
        closes = closes + 1'b1;
      end else begin
        held_digit = dval;
        held_valid = 1'b1;
      end
    end
    if (item.last_char) begin
      if (held_valid) acc_total = acc_total + {22'd0, held_digit};
      // unknown symbol wins over unbalanced parentheses
      if (bad_seen) begin
        res.value  = '0;
        res.status = rnd_pkg::STATUS_UNKNOWN;
      end else if (opens != closes) begin
        res.value  = '0;
        res.status = rnd_pkg::STATUS_UNBALANCED;
      end else begin
        res.value  = acc_total;
        res.status = rnd_pkg::STATUS_OK;
      end
      numeral_q.push_back(res);
      clear_numeral();
    end
  endtask

  task automatic push_char(logic [7:0] sym, logic last);
    rnd_pkg::in_t item;
    item.symbol    = sym;
    item.last_char = last;
    char_q.push_back(item);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_digit();
    case ($urandom_range(0, 6))
      0: return rnd_pkg::CH_M;
      1: return rnd_pkg::CH_D;
      2: return rnd_pkg::CH_C;
      3: return rnd_pkg::CH_L;
      4: return rnd_pkg::CH_X;
      5: return rnd_pkg::CH_V;
      default: return rnd_pkg::CH_I;
    endcase
  endfunction

  function automatic logic [7:0] pick_known();
    case ($urandom_range(0, 8))
      7: return rnd_pkg::CH_OPEN;
      8: return rnd_pkg::CH_CLOSE;
      default: return pick_digit();
    endcase
  endfunction

  // one random numeral; returns the number of characters queued
  task automatic push_random_numeral(output int n);
    logic [7:0] seq[$];
    int mode;
    int depth;
    mode = $urandom_range(0, 9);
    if (mode <= 5 || mode == 8) begin
      // nested groups of digits with matching parentheses
      for (int s = $urandom_range(1, 3); s > 0; s--) begin
        depth = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        for (int k = 0; k < depth; k++) seq.push_back(rnd_pkg::CH_OPEN);
        for (int k = $urandom_range(1, 4); k > 0; k--) seq.push_back(pick_digit());
        for (int k = 0; k < depth; k++) seq.push_back(rnd_pkg::CH_CLOSE);
      end
      for (int k = $urandom_range(0, 2); k > 0; k--) seq.push_back(pick_digit());
      // corrupt one position with an arbitrary byte
      if (mode == 8) seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (mode <= 7) begin
      for (int k = $urandom_range(1, 10); k > 0; k--) seq.push_back(pick_known());
    end else begin
      for (int k = $urandom_range(1, 4); k > 0; k--) seq.push_back(8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < seq.size(); i++) push_char(seq[i], i == seq.size() - 1);
    n = seq.size();
  endtask

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) decode_char(in_data);
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (char_q.size() != 0) begin
        in_data  <= char_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off to back up the input
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  stall_pct = 0;
  int  phase_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        phase_left <= $urandom_range(16, 96);
      end else begin
        phase_left <= phase_left - 1;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: compare each result transaction with the oldest decoded number
  rnd_pkg::out_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (numeral_q.size() == 0) begin
        $error("unexpected result: value %0d status %0d", out_data.value, out_data.status);
        errors++;
      end else begin
        want = numeral_q.pop_front();
        if (out_data.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, out_data.value);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  // stimulus and end of run
  initial begin
    int sent;
    int n;
    clear_numeral();
    // directed numerals
    push_text("MDCLXVI");
    push_text("IV");
    push_text("(((M)))");
    push_text("(X)");
    push_text("a");
    push_char(rnd_pkg::CH_OPEN, 1'b0);
    push_char(8'hFF, 1'b1);
    push_char(rnd_pkg::CH_CLOSE, 1'b1);
    push_char(8'h00, 1'b1);
    // random numerals
    sent = 0;
    while (sent < RANDOM_CHARS) begin
      push_random_numeral(n);
      sent += n;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (char_q.size() != 0 || in_valid) @(posedge clk);
    while (numeral_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ roman_numeral_decoder_unit.f @@
+incdir+sv
sv/rnd_pkg.sv
sv/rnd_in_stage.sv
sv/rnd_core.sv
sv/rnd_out_stage.sv
sv/roman_numeral_decoder_unit.sv
tb/roman_numeral_decoder_unit_tb.sv
